### design/mei_pkg.sv
package mei_pkg;

  // Field widths fixed by the Q4.28 data format and the count register.
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned COUNT_W       = 16;
  localparam int unsigned FRAC_BITS_DEF = 28;

  // Reset value of the iteration limit register.
  localparam logic [COUNT_W-1:0] LIMIT_RESET = 16'd256;

  // One input point: starting z and constant c.
  typedef struct packed {
    logic signed [DATA_W-1:0] start_real;
    logic signed [DATA_W-1:0] start_imag;
    logic signed [DATA_W-1:0] const_real;
    logic signed [DATA_W-1:0] const_imag;
  } point_t;

  // One result: repeat count, inside flag and the last z.
  typedef struct packed {
    logic [COUNT_W-1:0]       iter_count;
    logic                     inside_set;
    logic signed [DATA_W-1:0] final_real;
    logic signed [DATA_W-1:0] final_imag;
  } result_t;

endpackage

### design/mandelbrot_escape_iteration_unit.sv
// Mandelbrot escape-time unit. A point (start z, constant c, signed fixed point
// with FRAC_BITS fraction bits) is taken when point_valid is high and point_stall
// is low; the unit forms z*z+c once, then repeats it while |z|^2 <= 4 and the
// repeat count is below the iteration limit, and returns the count, the inside
// flag and the last z (components saturate to 32 bits). A single 32x32 signed
// multiplier is shared by the three products of every step, so each step runs
// through ST_SQR, ST_SQI and ST_CHK (the products), then ST_UPD (the update).
// When the previous result has already been taken, the result is loaded into
// the output register as the unit returns to idle, and the unit can take the
// next point while that result is shown. A finished result waits in the output
// register while the next point is already being worked on. The limit register
// (reset 256) is written through the cfg channel while the unit is idle.
module mandelbrot_escape_iteration_unit #(
  parameter int unsigned FRAC_BITS = mei_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         point_valid,
  output logic                         point_stall,
  input  mei_pkg::point_t              point,
  output logic                         result_valid,
  input  logic                         result_stall,
  output mei_pkg::result_t             result,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [mei_pkg::COUNT_W-1:0]  cfg_data
);
  import mei_pkg::*;

  // Sequencer codes.
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQR  = 3'd1;
  localparam logic [2:0] ST_SQI  = 3'd2;
  localparam logic [2:0] ST_CHK  = 3'd3;
  localparam logic [2:0] ST_UPD  = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  localparam int unsigned PROD_W = 2 * DATA_W;

  // Escape threshold 4 in the squared format; beyond 64 bits every point passes.
  localparam bit             BOUND_ALL = (2 * FRAC_BITS + 2) >= PROD_W;
  localparam logic [PROD_W:0] BOUND    =
      BOUND_ALL ? '0 : ((PROD_W+1)'(1) << (2 * FRAC_BITS + 2));

  logic [2:0]                state;
  logic                      first;
  logic [COUNT_W-1:0]        limit;
  logic [COUNT_W-1:0]        count;
  logic signed [DATA_W-1:0]  zr;
  logic signed [DATA_W-1:0]  zi;
  logic signed [DATA_W-1:0]  cr;
  logic signed [DATA_W-1:0]  ci;
  logic signed [PROD_W-1:0]  p_rr;
  logic signed [PROD_W-1:0]  p_ii;
  logic signed [PROD_W-1:0]  p_ri;
  logic signed [PROD_W-1:0]  diff;

  logic signed [DATA_W-1:0]  mul_a;
  logic signed [DATA_W-1:0]  mul_b;
  logic signed [PROD_W-1:0]  product;
  logic [PROD_W:0]           mag;
  logic                      in_bound;
  logic                      go_on;
  logic signed [PROD_W-1:0]  re_shift;
  logic signed [PROD_W-1:0]  im_shift;
  logic signed [DATA_W-1:0]  zr_next;
  logic signed [DATA_W-1:0]  zi_next;
  logic                      out_free;

  // Clamp a 65-bit sum into the 32-bit signed range.
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W:0] v);
    logic signed [DATA_W-1:0] r;
    if (v[PROD_W:DATA_W-1] == '0 || v[PROD_W:DATA_W-1] == '1) begin
      r = v[DATA_W-1:0];
    end else if (v[PROD_W]) begin
      r = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(DATA_W-1){1'b1}}};
    end
    return r;
  endfunction

  assign point_stall = (state != ST_IDLE);
  assign cfg_ready   = (state == ST_IDLE);
  assign out_free    = !result_valid || !result_stall;

  // Operand selection for the shared multiplier.
  always_comb begin
    unique case (state)
      ST_SQR: begin
        mul_a = zr;
        mul_b = zr;
      end
      ST_SQI: begin
        mul_a = zi;
        mul_b = zi;
      end
      default: begin
        mul_a = zr;
        mul_b = zi;
      end
    endcase
  end

  assign product = mul_a * mul_b;

  // Bound test on the squares of the current z.
  assign mag      = {1'b0, p_rr} + {1'b0, p_ii};
  assign in_bound = BOUND_ALL || (mag <= BOUND);
  assign go_on    = first || (in_bound && (count != limit));

  // Update of z from the registered products.
  assign re_shift = diff >>> FRAC_BITS;
  assign im_shift = p_ri >>> (FRAC_BITS - 1);
  assign zr_next  = sat32({re_shift[PROD_W-1], re_shift} + (PROD_W+1)'(cr));
  assign zi_next  = sat32({im_shift[PROD_W-1], im_shift} + (PROD_W+1)'(ci));

  // Limit register.
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      limit <= cfg_data;
    end
  end

  // Sequencer and working registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      first <= 1'b0;
      count <= '0;
      zr    <= '0;
      zi    <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (point_valid) begin
            zr    <= point.start_real;
            zi    <= point.start_imag;
            cr    <= point.const_real;
            ci    <= point.const_imag;
            count <= '0;
            first <= 1'b1;
            state <= ST_SQR;
          end
        end
        ST_SQR: begin
          p_rr  <= product;
          state <= ST_SQI;
        end
        ST_SQI: begin
          p_ii  <= product;
          state <= ST_CHK;
        end
        ST_CHK: begin
          p_ri <= product;
          diff <= p_rr - p_ii;
          if (go_on) begin
            if (!first) begin
              count <= count + 1'b1;
            end
            first <= 1'b0;
            state <= ST_UPD;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_UPD: begin
          zr    <= zr_next;
          zi    <= zi_next;
          state <= ST_SQR;
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output register: loaded when a point finishes, cleared on a transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      result_valid <= 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      result.iter_count <= count;
      result.inside_set <= (count == limit);
      result.final_real <= zr;
      result.final_imag <= zi;
    end
  end

  // A new result only ever comes out of the finishing state.
  assert property (@(posedge clk) disable iff (rst)
    (!result_valid ##1 result_valid) |-> ($past(state) == ST_DONE))
    else $error("result raised outside the finishing state");

  // The repeat count never passes the limit while a point is in work.
  assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> (count <= limit))
    else $error("repeat count passed the iteration limit");

  // A point transfer starts a fresh first step.
  assert property (@(posedge clk) disable iff (rst)
    (point_valid && !point_stall) |=> (state == ST_SQR && first && count == '0))
    else $error("point transfer did not start the first step");

endmodule
